[sv/sfr_pkg.sv]
package sfr_pkg;

    localparam logic [7:0] HDR_BYTE     = 8'hFF;
    localparam logic [7:0] TYPE_READING = 8'h86;
    localparam logic [7:0] TYPE_MODE    = 8'h78;
    localparam logic [7:0] MODE_OK      = 8'h01;

    // byte_position codes: 0 hunting, 1..7 body, 8 checksum
    localparam int unsigned BODY_LEN  = 7;
    localparam logic [3:0]  POS_HUNT  = 4'd0;
    localparam logic [3:0]  POS_FIRST = 4'd1;
    localparam logic [3:0]  POS_LAST  = 4'd7;
    localparam logic [3:0]  POS_CHECK = 4'd8;

    // frame queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       is_mode;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] b7;
    } t_frame;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_head;

endpackage

[sv/sensor_frame_receiver.sv]
// Sensor frame receiver.
// Input channel: one raw serial byte per item on i_rx_byte, qualified by
// i_valid; an item is taken at a clock edge where i_valid is high and
// o_stall is low. Bytes are taken back to back, one per cycle, while o_stall is low.
// The block hunts for the 0xFF header, collects eight more bytes, checks
// the negated 8-bit checksum over bytes 1..7 and the type byte (0x86 or
// 0x78). A passing frame yields one item on the output channel; a failing
// frame is dropped and hunting restarts with the next byte.
// Output channel: o_valid with the frame fields, taken at an edge where
// o_valid is high and i_stall is low.
// Path: the edge that takes the checksum byte writes the frame into the
// queue; the back's output register loads it at an edge where that
// register is empty or not stalled, and o_valid then shows the result.
// Throughput: one byte per cycle while o_stall is low. A two-entry frame
// queue sits between front and back, so o_stall rises only once two frames
// wait behind a result the receiver keeps stalled; the output holds
// steady meanwhile. Reset (synchronous, active low) empties the queue,
// drops o_valid and returns the front to hunting.
module sensor_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_type,
    output logic [7:0]  o_payload_two,
    output logic [7:0]  o_payload_three,
    output logic [7:0]  o_payload_four,
    output logic [7:0]  o_payload_five,
    output logic [7:0]  o_payload_six,
    output logic [7:0]  o_payload_seven,
    output logic [15:0] o_concentration,
    output logic        o_mode_ack
);

    sfr_pkg::t_push w_push;
    sfr_pkg::t_head w_head;
    logic           w_q_full;
    logic           w_pop;

    // front: hunt, collect, verify; push passing frames
    sfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (w_q_full),
        .o_stall   (o_stall),
        .o_push    (w_push)
    );

    // queue: decouple front from a stalled receiver
    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    // back: format fields and hold the output register
    sfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_stall         (i_stall),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .o_frame_type    (o_frame_type),
        .o_payload_two   (o_payload_two),
        .o_payload_three (o_payload_three),
        .o_payload_four  (o_payload_four),
        .o_payload_five  (o_payload_five),
        .o_payload_six   (o_payload_six),
        .o_payload_seven (o_payload_seven),
        .o_concentration (o_concentration),
        .o_mode_ack      (o_mode_ack)
    );

endmodule

[sv/sfr_front.sv]
module sfr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_q_full,
    output logic           o_stall,
    output sfr_pkg::t_push o_push
);

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [7:0] r_held [sfr_pkg::BODY_LEN];
    logic       w_accept;
    logic [7:0] w_expect;
    logic       w_kind_ok;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_expect = 8'(8'd0 - r_sum);
    assign w_kind_ok = (r_held[0] == sfr_pkg::TYPE_READING) ||
                       (r_held[0] == sfr_pkg::TYPE_MODE);

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        o_push.valid         = 1'b0;
        o_push.frame.is_mode = (r_held[0] == sfr_pkg::TYPE_MODE);
        o_push.frame.b2      = r_held[1];
        o_push.frame.b3      = r_held[2];
        o_push.frame.b4      = r_held[3];
        o_push.frame.b5      = r_held[4];
        o_push.frame.b6      = r_held[5];
        o_push.frame.b7      = r_held[6];
        if (w_accept) begin
            if (r_pos inside {[sfr_pkg::POS_FIRST:sfr_pkg::POS_LAST]}) begin
                n_sum = 8'(r_sum + i_rx_byte);
                n_pos = 4'(r_pos + 4'd1);
            end else if (r_pos == sfr_pkg::POS_CHECK) begin
                // close the frame; push only if checksum and type both pass
                n_pos = sfr_pkg::POS_HUNT;
                n_sum = 8'd0;
                o_push.valid = (i_rx_byte == w_expect) && w_kind_ok;
            end else if (i_rx_byte == sfr_pkg::HDR_BYTE) begin
                n_pos = sfr_pkg::POS_FIRST;
                n_sum = 8'd0;
            end else begin
                n_pos = sfr_pkg::POS_HUNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= sfr_pkg::POS_HUNT;
            r_sum <= 8'd0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // capture body bytes at their slot
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < sfr_pkg::BODY_LEN; k++) begin
            if (w_accept && (r_pos == 4'(sfr_pkg::POS_FIRST + 4'(k)))) begin
                r_held[k] <= i_rx_byte;
            end
        end
    end

endmodule

[sv/sfr_queue.sv]
module sfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfr_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output sfr_pkg::t_head o_head
);

    sfr_pkg::t_frame               r_data [sfr_pkg::QUEUE_DEPTH];
    logic [sfr_pkg::QUEUE_AW-1:0]  r_wr;
    logic [sfr_pkg::QUEUE_AW-1:0]  r_rd;
    logic [sfr_pkg::QUEUE_CW-1:0]  r_count;
    logic                          w_push;
    logic                          w_pop;

    assign o_full       = (r_count == sfr_pkg::QUEUE_CW'(sfr_pkg::QUEUE_DEPTH));
    assign w_push       = i_push.valid && !o_full;
    assign w_pop        = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.frame = r_data[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == sfr_pkg::QUEUE_AW'(sfr_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : sfr_pkg::QUEUE_AW'(r_wr + 1'b1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == sfr_pkg::QUEUE_AW'(sfr_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : sfr_pkg::QUEUE_AW'(r_rd + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_count <= sfr_pkg::QUEUE_CW'(r_count + 1'b1);
            end else if (w_pop && !w_push) begin
                r_count <= sfr_pkg::QUEUE_CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr] <= i_push.frame;
        end
    end

endmodule

[sv/sfr_back.sv]
module sfr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfr_pkg::t_head i_head,
    input  logic           i_stall,
    output logic           o_pop,
    output logic           o_valid,
    output logic           o_frame_type,
    output logic [7:0]     o_payload_two,
    output logic [7:0]     o_payload_three,
    output logic [7:0]     o_payload_four,
    output logic [7:0]     o_payload_five,
    output logic [7:0]     o_payload_six,
    output logic [7:0]     o_payload_seven,
    output logic [15:0]    o_concentration,
    output logic           o_mode_ack
);

    logic r_valid;
    logic w_load;

    assign w_load  = i_head.valid && (!r_valid || !i_stall);
    assign o_pop   = w_load;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // format the result on load; hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_frame_type    <= i_head.frame.is_mode;
            o_payload_two   <= i_head.frame.b2;
            o_payload_three <= i_head.frame.b3;
            o_payload_four  <= i_head.frame.b4;
            o_payload_five  <= i_head.frame.b5;
            o_payload_six   <= i_head.frame.b6;
            o_payload_seven <= i_head.frame.b7;
            o_concentration <= {i_head.frame.b2, i_head.frame.b3};
            o_mode_ack      <= i_head.frame.is_mode && (i_head.frame.b2 == sfr_pkg::MODE_OK);
        end
    end

endmodule

[sv/sfr_checker.sv]
module sfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_frame_type,
    input logic [7:0]  o_payload_two,
    input logic [7:0]  o_payload_three,
    input logic [15:0] o_concentration,
    input logic        o_mode_ack
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_valid && i_stall |=> o_valid && $stable(o_concentration)
        && $stable(o_frame_type))
        else $error("stalled result changed");

    a_conc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_concentration == {o_payload_two, o_payload_three})
        else $error("concentration does not match payload bytes");

    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mode_ack |-> o_frame_type && (o_payload_two == sfr_pkg::MODE_OK))
        else $error("mode_ack without mode reply and byte two of one");

    a_rst_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_frame_type    (o_frame_type),
    .o_payload_two   (o_payload_two),
    .o_payload_three (o_payload_three),
    .o_concentration (o_concentration),
    .o_mode_ack      (o_mode_ack)
);

[bench/tb_sensor_frame_receiver.sv]
`timescale 1ns / 100ps

module tb_sensor_frame_receiver;

    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Frame checker: tracks the hunt/collect/check sequence on every
    // accepted byte and queues the frame that a passing checksum yields.
    class frame_scoreboard;
        logic [3:0]       position;
        logic [7:0]       body_sum;
        logic [7:0]       body [sfr_pkg::BODY_LEN];
        sfr_pkg::t_frame  due_frames [$];
        int unsigned      faults;

        function new();
            position = sfr_pkg::POS_HUNT;
            body_sum = 8'h00;
            faults   = 0;
            foreach (body[k]) body[k] = 8'h00;
        endfunction

        function void note_byte(logic [7:0] value);
            logic [7:0]      want_sum;
            sfr_pkg::t_frame f;
            if (position >= sfr_pkg::POS_FIRST && position <= sfr_pkg::POS_LAST) begin
                // body byte: hold it and fold it into the sum
                body[position - sfr_pkg::POS_FIRST] = value;
                body_sum = body_sum + value;
                position = position + 4'd1;
            end else if (position == sfr_pkg::POS_CHECK) begin
                want_sum = 8'h00 - body_sum;
                position = sfr_pkg::POS_HUNT;
                body_sum = 8'h00;
                if (value == want_sum &&
                    (body[0] == sfr_pkg::TYPE_READING ||
                     body[0] == sfr_pkg::TYPE_MODE)) begin
                    f.is_mode = (body[0] == sfr_pkg::TYPE_MODE);
                    f.b2 = body[1];
                    f.b3 = body[2];
                    f.b4 = body[3];
                    f.b5 = body[4];
                    f.b6 = body[5];
                    f.b7 = body[6];
                    due_frames.push_back(f);
                end
            end else begin
                // hunting: only the header opens a frame
                position = (value == sfr_pkg::HDR_BYTE) ? sfr_pkg::POS_FIRST
                                                        : sfr_pkg::POS_HUNT;
                body_sum = 8'h00;
            end
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                faults++;
            end
        endfunction

        function void check_frame(logic ftype, logic [7:0] p2, logic [7:0] p3,
                                  logic [7:0] p4, logic [7:0] p5, logic [7:0] p6,
                                  logic [7:0] p7, logic [15:0] conc, logic ack);
            sfr_pkg::t_frame f;
            if (due_frames.size() == 0) begin
                $display("%0t: frame result with none expected, expected none, actual %0h %0h",
                         $time, ftype, conc);
                faults++;
                return;
            end
            f = due_frames.pop_front();
            check_field("frame_type",    16'(f.is_mode), 16'(ftype));
            check_field("payload_two",   16'(f.b2), 16'(p2));
            check_field("payload_three", 16'(f.b3), 16'(p3));
            check_field("payload_four",  16'(f.b4), 16'(p4));
            check_field("payload_five",  16'(f.b5), 16'(p5));
            check_field("payload_six",   16'(f.b6), 16'(p6));
            check_field("payload_seven", 16'(f.b7), 16'(p7));
            check_field("concentration", {f.b2, f.b3}, conc);
            check_field("mode_ack", 16'(f.is_mode && f.b2 == sfr_pkg::MODE_OK), 16'(ack));
        endfunction

        function int unsigned pending();
            return due_frames.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_frame_type;
    logic [7:0]  o_payload_two;
    logic [7:0]  o_payload_three;
    logic [7:0]  o_payload_four;
    logic [7:0]  o_payload_five;
    logic [7:0]  o_payload_six;
    logic [7:0]  o_payload_seven;
    logic [15:0] o_concentration;
    logic        o_mode_ack;

    frame_scoreboard board;
    int unsigned     frames_taken = 0;
    int unsigned     cycle_count  = 0;
    logic            tx_eager     = 1'b0;

    sensor_frame_receiver u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_rx_byte       (i_rx_byte),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_frame_type    (o_frame_type),
        .o_payload_two   (o_payload_two),
        .o_payload_three (o_payload_three),
        .o_payload_four  (o_payload_four),
        .o_payload_five  (o_payload_five),
        .o_payload_six   (o_payload_six),
        .o_payload_seven (o_payload_seven),
        .o_concentration (o_concentration),
        .o_mode_ack      (o_mode_ack)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Monitor both channels on the clock edge; values seen here are the
    // ones the block itself samples at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                board.check_frame(o_frame_type, o_payload_two, o_payload_three,
                                  o_payload_four, o_payload_five, o_payload_six,
                                  o_payload_seven, o_concentration, o_mode_ack);
                frames_taken++;
            end
            if (i_valid && !o_stall)
                board.note_byte(i_rx_byte);
        end
    end

    // Offer one byte after a random gap, then hold it until taken.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = tx_eager ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Send header, body bytes 1..7 (body[0] is byte 1) and a checksum.
    // A nonzero skew corrupts the checksum.
    task automatic send_frame(input logic [6:0][7:0] body, input logic [7:0] skew);
        logic [7:0] sum;
        sum = 8'h00;
        send_byte(sfr_pkg::HDR_BYTE);
        for (int k = 0; k < sfr_pkg::BODY_LEN; k++) begin
            send_byte(body[k]);
            sum = sum + body[k];
        end
        send_byte(8'h00 - sum + skew);
    endtask

    task automatic run_directed();
        // noise while hunting is dropped
        send_byte(8'hFE);
        // reading reply, header value as data, full-scale concentration
        send_frame({8'hAA, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, sfr_pkg::TYPE_READING},
                   8'h00);
        // mode reply with acknowledge
        send_frame({8'h78, 8'h56, 8'h34, 8'h12, 8'h00, sfr_pkg::MODE_OK,
                    sfr_pkg::TYPE_MODE}, 8'h00);
        // good checksum but unknown type (header value in type slot): drop
        send_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, sfr_pkg::HDR_BYTE},
                   8'h00);
    endtask

    task automatic run_random();
        int unsigned       frame_bytes;
        int unsigned       pick;
        int unsigned       noise;
        logic [6:0][7:0]   body;
        logic [7:0]        skew;
        frame_bytes = 0;
        while (frame_bytes < RANDOM_ITEMS) begin
            tx_eager = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            for (int k = 0; k < sfr_pkg::BODY_LEN; k++) body[k] = 8'($urandom);
            skew = 8'h00;
            if (pick < 80) begin
                body[0] = $urandom_range(0, 1) ? sfr_pkg::TYPE_MODE : sfr_pkg::TYPE_READING;
                if (body[0] == sfr_pkg::TYPE_MODE && $urandom_range(0, 2) == 0)
                    body[1] = sfr_pkg::MODE_OK;
                // corrupt the checksum on a slice of the well-formed frames
                if (pick >= 70)
                    skew = 8'($urandom_range(1, 255));
            end
            if (pick < 88) begin
                send_frame(body, skew);
                frame_bytes += 9;
            end else begin
                // noise and broken frames; a stray header swallows what follows
                noise = $urandom_range(1, 4);
                repeat (noise)
                    send_byte(($urandom_range(0, 2) == 0) ? sfr_pkg::HDR_BYTE
                                                          : 8'($urandom));
                frame_bytes += noise;
            end
        end
    endtask

    // Result side: stall for a random gap before each item, with eager
    // stretches, and twice a long hold-off that fills the frame queue so
    // that the block must stall its input.
    initial begin : result_sink
        int unsigned wait_cycles;
        int unsigned holds_left;
        int unsigned hold_at;
        int unsigned eager_left;
        logic        rx_eager;
        holds_left = 2;
        hold_at    = 10;
        eager_left = 0;
        rx_eager   = 1'b0;
        forever begin
            if (eager_left == 0) begin
                eager_left = $urandom_range(5, 20);
                rx_eager   = ($urandom_range(0, 2) == 0);
            end
            eager_left--;
            if (holds_left > 0 && frames_taken >= hold_at) begin
                wait_cycles = LONG_HOLD;
                holds_left--;
                hold_at += 60;
            end else begin
                wait_cycles = rx_eager ? 0 : $urandom_range(0, 4);
            end
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random();
        i_valid <= 1'b0;

        // drain: let the monitor note the last byte, wait out every queued
        // frame, then the block's latency
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.faults == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
